// File: sv/swh_pkg.sv
`default_nettype none
package swh_pkg;

   // Widths fixed by the item fields
   localparam int IDENT_WIDTH = 16;
   localparam int CNT_BITS    = 11;

   // Defaults for the top-level parameters
   localparam int DEF_HISTORY_DEPTH = 1024;
   localparam int DEF_IDENT_BITS    = 16;

   // Occurrence counts saturate here
   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

   // Threshold after reset
   localparam logic [CNT_BITS-1:0] THRESH_RESET = CNT_BITS'(1);

   // One result item
   typedef struct packed {
      logic [CNT_BITS-1:0] active_count;
      logic                window_full;
      logic [CNT_BITS-1:0] ident_count;
   } rsp_item_type;

endpackage
`default_nettype wire

// File: sv/swh_req_if.sv
`default_nettype none
interface swh_req_if;
   import swh_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [IDENT_WIDTH-1:0] ident;

   modport source (output valid, output ident, input ready);
   modport sink   (input valid, input ident, output ready);
endinterface
`default_nettype wire

// File: sv/swh_rsp_if.sv
`default_nettype none
interface swh_rsp_if;
   import swh_pkg::*;

   logic                valid;
   logic                ready;
   logic [CNT_BITS-1:0] active_count;
   logic                window_full;
   logic [CNT_BITS-1:0] ident_count;

   modport source (output valid, output active_count, output window_full,
                   output ident_count, input ready);
   modport sink   (input valid, input active_count, input window_full,
                   input ident_count, output ready);
endinterface
`default_nettype wire

// File: sv/sliding_window_id_histogram_top.sv
`default_nettype none
// Channel   Dir  Handshake        Payload
// req_if    in   valid / ready    ident
// rsp_if    out  valid / ready    active_count, window_full, ident_count
// csr_*     in   csr_wr_en        csr_wr_data (activity threshold)
//
// Items are spaced apart: the occurrence table memory has one read and one write
// port, and each item needs up to two read-modify-writes of it.
// Each accepted item passes through stages s1, s2 and s3 before its result is
// written into the response queue; up to 4 items may be outstanding, so a
// stalled consumer holds off new items. After reset a clearing pass zeroes the
// occurrence table, during which no item is taken.
module sliding_window_id_histogram_top #(
   parameter int HISTORY_DEPTH = swh_pkg::DEF_HISTORY_DEPTH,
   parameter int IDENT_BITS    = swh_pkg::DEF_IDENT_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   swh_req_if.sink                           req_if,
   swh_rsp_if.source                         rsp_if,
   input  wire logic                         csr_wr_en,
   input  wire logic [swh_pkg::CNT_BITS-1:0] csr_wr_data
);
   import swh_pkg::*;

   localparam int RING_AW   = $clog2(HISTORY_DEPTH);
   localparam int TBL_DEPTH = 1 << IDENT_BITS;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   localparam logic [RING_AW-1:0]    RING_LAST = RING_AW'(HISTORY_DEPTH - 1);
   localparam logic [IDENT_BITS-1:0] TBL_LAST  = {IDENT_BITS{1'b1}};

   // Configuration
   logic [CNT_BITS-1:0] thresh_ff;

   // Control state
   logic                clr_active_ff;
   logic [IDENT_BITS-1:0] clr_addr_ff;
   logic                accept_last_ff;
   logic [RING_AW-1:0]  ring_pos_ff, ring_pos_in;
   logic                wrapped_ff, wrapped_in;
   logic [CNT_BITS-1:0] active_ff, active_in;
   logic [RSP_CW-1:0]   outstanding_ff;

   // Pipeline stages
   logic                  s1_valid_ff, s1_evict_ff, s1_full_ff;
   logic [IDENT_BITS-1:0] s1_id_ff;
   logic                  s2_valid_ff, s2_evict_ff, s2_full_ff;
   logic [IDENT_BITS-1:0] s2_id_ff, s2_old_ff;
   logic                  s3_valid_ff, s3_full_ff;
   logic [IDENT_BITS-1:0] s3_id_ff;

   // Memory ports
   logic                  ring_rd_en;
   logic [IDENT_BITS-1:0] ring_rd_data;
   logic [IDENT_BITS-1:0] old_id;
   logic                  tbl_rd_en, tbl_wr_en;
   logic [IDENT_BITS-1:0] tbl_rd_addr, tbl_wr_addr;
   logic [CNT_BITS-1:0]   tbl_wr_data, tbl_rd_data;
   logic                  fwd_hit_ff;
   logic [CNT_BITS-1:0]   fwd_data_ff;

   // Datapath
   logic                  accept, last_slot;
   logic [CNT_BITS-1:0]   cnt_rd, dec_cnt, inc_cnt;
   logic                  dec_hit, inc_hit, evict_wr;

   // Response queue
   rsp_item_type          rsp_q_ff [RSP_DEPTH];
   logic [RSP_AW-1:0]     rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic [RSP_CW-1:0]     rsp_cnt_ff;
   rsp_item_type          rsp_head, rsp_push_item;
   logic                  rsp_push, rsp_pop;

   // Accept with spacing between items, with room reserved in the queue
   assign req_if.ready = !clr_active_ff && !accept_last_ff
                         && (outstanding_ff < RSP_CW'(RSP_DEPTH));
   assign accept       = req_if.valid && req_if.ready;

   assign last_slot   = (ring_pos_ff == RING_LAST);
   assign ring_pos_in = last_slot ? '0 : ring_pos_ff + RING_AW'(1);
   assign wrapped_in  = wrapped_ff | last_slot;

   // History ring: read the evicted identifier and write the new one at once
   assign ring_rd_en = accept;

   swh_ram #(
      .WIDTH (IDENT_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ring_pos_ff),
      .wr_data (req_if.ident[IDENT_BITS-1:0]),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_pos_ff),
      .rd_data (ring_rd_data)
   );

   assign old_id = ring_rd_data;

   // Forward a write that lands on the address being read in the same cycle
   assign cnt_rd = fwd_hit_ff ? fwd_data_ff : tbl_rd_data;

   // Eviction step (stage 2) and increment step (stage 3)
   assign dec_cnt  = (cnt_rd == '0) ? '0 : cnt_rd - CNT_BITS'(1);
   assign inc_cnt  = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + CNT_BITS'(1);
   assign evict_wr = s2_valid_ff && s2_evict_ff;
   assign dec_hit  = evict_wr && (cnt_rd == thresh_ff);
   assign inc_hit  = s3_valid_ff && (inc_cnt == thresh_ff);

   assign active_in = active_ff + CNT_BITS'(inc_hit) - CNT_BITS'(dec_hit);

   // Table read: evicted identifier in stage 1, new identifier in stage 2
   always_comb begin
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = old_id;
      if (s2_valid_ff) begin
         tbl_rd_en   = 1'b1;
         tbl_rd_addr = s2_id_ff;
      end else if (s1_valid_ff && s1_evict_ff) begin
         tbl_rd_en   = 1'b1;
         tbl_rd_addr = old_id;
      end
   end

   // Table write: clearing pass, increment, or decrement
   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = clr_addr_ff;
      tbl_wr_data = '0;
      if (clr_active_ff) begin
         tbl_wr_en = 1'b1;
      end else if (s3_valid_ff) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = s3_id_ff;
         tbl_wr_data = inc_cnt;
      end else if (evict_wr) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = s2_old_ff;
         tbl_wr_data = dec_cnt;
      end
   end

   swh_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Capture write data for forwarding
   always_ff @(posedge clock) begin
      fwd_data_ff <= tbl_wr_data;
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= tbl_rd_en && tbl_wr_en && (tbl_rd_addr == tbl_wr_addr);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff      <= THRESH_RESET;
         clr_active_ff  <= 1'b1;
         clr_addr_ff    <= '0;
         accept_last_ff <= 1'b0;
         ring_pos_ff    <= '0;
         wrapped_ff     <= 1'b0;
         active_ff      <= '0;
         outstanding_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + IDENT_BITS'(1);
            if (clr_addr_ff == TBL_LAST) begin
               clr_active_ff <= 1'b0;
            end
         end
         accept_last_ff <= accept;
         if (accept) begin
            ring_pos_ff <= ring_pos_in;
            wrapped_ff  <= wrapped_in;
         end
         active_ff      <= active_in;
         outstanding_ff <= outstanding_ff + RSP_CW'(accept) - RSP_CW'(rsp_pop);
         s1_valid_ff    <= accept;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
      end
   end

   // Advance the payload through the stages
   always_ff @(posedge clock) begin
      s1_id_ff    <= req_if.ident[IDENT_BITS-1:0];
      s1_evict_ff <= wrapped_ff;
      s1_full_ff  <= wrapped_in;
      s2_id_ff    <= s1_id_ff;
      s2_old_ff   <= old_id;
      s2_evict_ff <= s1_evict_ff;
      s2_full_ff  <= s1_full_ff;
      s3_id_ff    <= s2_id_ff;
      s3_full_ff  <= s2_full_ff;
   end

   // Response queue
   assign rsp_push                   = s3_valid_ff;
   assign rsp_pop                    = rsp_if.valid && rsp_if.ready;
   assign rsp_push_item.active_count = active_in;
   assign rsp_push_item.window_full  = s3_full_ff;
   assign rsp_push_item.ident_count  = inc_cnt;

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_q_ff[rsp_wr_ptr_ff] <= rsp_push_item;
      end
      if (reset) begin
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_cnt_ff    <= '0;
      end else begin
         if (rsp_push) begin
            rsp_wr_ptr_ff <= rsp_wr_ptr_ff + RSP_AW'(1);
         end
         if (rsp_pop) begin
            rsp_rd_ptr_ff <= rsp_rd_ptr_ff + RSP_AW'(1);
         end
         rsp_cnt_ff <= rsp_cnt_ff + RSP_CW'(rsp_push) - RSP_CW'(rsp_pop);
      end
   end

   assign rsp_head            = rsp_q_ff[rsp_rd_ptr_ff];
   assign rsp_if.valid        = (rsp_cnt_ff != '0);
   assign rsp_if.active_count = rsp_head.active_count;
   assign rsp_if.window_full  = rsp_head.window_full;
   assign rsp_if.ident_count  = rsp_head.ident_count;

   // Items are spaced so the table ports are never claimed twice
   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      accept |=> !accept)
      else $error("item accepted in consecutive cycles");

   a_no_clear_overlap: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !tbl_rd_en && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("table accessed during clearing pass");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_cnt_ff < RSP_CW'(RSP_DEPTH)) || rsp_pop)
      else $error("response queue overflow");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff <= outstanding_ff)
      else $error("queue holds more items than outstanding");

endmodule
`default_nettype wire

// File: sv/swh_ram.sv
`default_nettype none
module swh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; a read of the same address in the same cycle sees the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import swh_pkg::*;

   localparam int HIST_DEPTH   = DEF_HISTORY_DEPTH;
   localparam int ID_BITS      = DEF_IDENT_BITS;
   localparam int TABLE_SIZE   = 1 << ID_BITS;
   localparam int PIPE_LATENCY = 4;
   localparam int MAX_WAIT     = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [IDENT_WIDTH-1:0] ID_MASK = IDENT_WIDTH'(TABLE_SIZE - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en;
   logic [CNT_BITS-1:0] csr_wr_data;

   swh_req_if req_chan ();
   swh_rsp_if rsp_chan ();

   sliding_window_id_histogram_top #(
      .HISTORY_DEPTH (HIST_DEPTH),
      .IDENT_BITS    (ID_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the window and its histogram
   logic [CNT_BITS-1:0]    occ_count [TABLE_SIZE];
   logic [IDENT_WIDTH-1:0] window_ids [HIST_DEPTH];
   int unsigned            ring_slot;
   bit                     ring_wrapped;
   logic [CNT_BITS-1:0]    active_ids;
   logic [CNT_BITS-1:0]    threshold_now = THRESH_RESET;

   rsp_item_type expected_results [$];
   int unsigned  fault_count = 0;
   int unsigned  result_index = 0;
   int unsigned  cycle_count = 0;
   bit           steady_pace = 1'b0;

   initial forever #5 clock = ~clock;

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady_pace ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   // Slide the window by one identifier and return the expected item
   function automatic rsp_item_type predict_histogram(input logic [IDENT_WIDTH-1:0] ident);
      logic [IDENT_WIDTH-1:0] id;
      logic [IDENT_WIDTH-1:0] leaving;
      logic [CNT_BITS-1:0]    cnt;
      rsp_item_type           res;
      id = ident & ID_MASK;
      // drop the oldest identifier once the ring has wrapped
      if (ring_wrapped) begin
         leaving = window_ids[ring_slot] & ID_MASK;
         cnt = occ_count[leaving];
         if (cnt == threshold_now) active_ids = active_ids - 1'b1;
         if (cnt != '0) occ_count[leaving] = cnt - 1'b1;
      end
      // add the new identifier, saturating its count
      window_ids[ring_slot] = id;
      cnt = occ_count[id];
      if (cnt != CNT_MAX) cnt = cnt + 1'b1;
      occ_count[id] = cnt;
      if (cnt == threshold_now) active_ids = active_ids + 1'b1;
      // advance the ring
      if (ring_slot == HIST_DEPTH - 1) begin
         ring_wrapped = 1'b1;
         ring_slot = 0;
      end else begin
         ring_slot = ring_slot + 1;
      end
      res.active_count = active_ids;
      res.window_full  = ring_wrapped;
      res.ident_count  = cnt;
      return res;
   endfunction

   // Mostly a small pool so identifiers repeat, sometimes the top of the range or anything
   function automatic logic [IDENT_WIDTH-1:0] pick_ident(input int pool);
      case ($urandom_range(0, 9))
         0: return IDENT_WIDTH'($urandom);
         1: return IDENT_WIDTH'(ID_MASK - $urandom_range(0, pool - 1));
         default: return IDENT_WIDTH'($urandom_range(0, pool - 1));
      endcase
   endfunction

   task automatic note_fault(input string msg);
      if (fault_count < REPORT_LIMIT) $display("%s", msg);
      fault_count++;
   endtask

   // Offer one identifier and hold it until taken
   task automatic send_ident(input logic [IDENT_WIDTH-1:0] ident);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ident <= ident;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_results.push_back(predict_histogram(ident));
   endtask

   // Drop valid and let every outstanding item come back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [CNT_BITS-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold_now = value;
   endtask

   task automatic run_burst(input int count, input int pool);
      for (int i = 0; i < count; i++) begin
         // alternate stretches of random gaps and back-to-back traffic
         if (i % 40 == 0) steady_pace = ($urandom_range(0, 3) == 0);
         send_ident(pick_ident(pool));
      end
      steady_pace = 1'b0;
      wait_idle();
   endtask

   // Threshold left at its reset value, field extremes and alternating bits
   task automatic test_reset_threshold();
      send_ident('0);
      send_ident(ID_MASK);
      send_ident('0);
      send_ident(16'hAAAA);
      send_ident(16'h5555);
      send_ident(16'h0001);
      send_ident(16'h8000);
      send_ident(16'h7FFF);
      send_ident(ID_MASK);
      send_ident('0);
      wait_idle();
   endtask

   // Zero, top and mid thresholds, changed while the window holds counts
   task automatic test_threshold_extremes();
      set_threshold('0);
      send_ident(16'd5);
      send_ident(16'd5);
      send_ident(16'd5);
      set_threshold(CNT_MAX);
      send_ident(16'd5);
      send_ident(ID_MASK);
      set_threshold(CNT_BITS'(1024));
      send_ident(16'd9);
      set_threshold(CNT_BITS'(2));
      send_ident(16'd9);
      send_ident(16'd9);
      send_ident(16'd9);
      wait_idle();
   endtask

   // Grow the window under several thresholds and identifier pools
   task automatic test_sliding_window();
      set_threshold(CNT_BITS'(3));
      run_burst(120, 8);
      set_threshold(CNT_BITS'(1));
      run_burst(120, 64);
      set_threshold(CNT_BITS'(2));
      run_burst(120, 4);
      set_threshold(CNT_BITS'($urandom_range(1, 6)));
      run_burst(120, 16);
   endtask

   // Threshold extremes once the window holds many counts
   task automatic test_wrapped_extremes();
      set_threshold('0);
      run_burst(30, 8);
      set_threshold(CNT_MAX);
      run_burst(30, 2);
      set_threshold(CNT_BITS'(1));
      run_burst(30, 3);
   endtask

   // Result side: stall at random, compare each item with the oldest prediction
   initial begin
      rsp_item_type want;
      int           stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            note_fault($sformatf("unexpected result: active %0d full %0b count %0d",
                                 rsp_chan.active_count, rsp_chan.window_full,
                                 rsp_chan.ident_count));
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.active_count !== want.active_count ||
                rsp_chan.window_full !== want.window_full ||
                rsp_chan.ident_count !== want.ident_count) begin
               note_fault({$sformatf(
                  "result %0d mismatch: expected active %0d full %0b count %0d",
                  result_index, want.active_count, want.window_full,
                  want.ident_count),
                  $sformatf(", got active %0d full %0b count %0d",
                  rsp_chan.active_count, rsp_chan.window_full,
                  rsp_chan.ident_count)});
            end
         end
         result_index++;
      end
   end

   // Reset, run each test in turn, then drain
   initial begin
      req_chan.valid <= 1'b0;
      req_chan.ident <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) occ_count[i] = '0;
      ring_slot    = 0;
      ring_wrapped = 1'b0;
      active_ids   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_threshold();
      test_threshold_extremes();
      test_sliding_window();
      test_wrapped_extremes();

      wait_idle();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sliding_window_id_histogram_top.f
sv/swh_pkg.sv
sv/swh_req_if.sv
sv/swh_rsp_if.sv
sv/swh_ram.sv
sv/sliding_window_id_histogram_top.sv
tb/tb_top.sv
